// File: src/circular_deque_macros.svh
// Assertion macros for the circular deque RTL.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTHESIS

`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CDQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define CDQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: src/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int FILL_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ALL   = 3'd4;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] data;
    logic                    last;
    logic [FILL_W-1:0]       fill_count;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic pop_emit;
    logic dump_step;
  } cdq_ctl_t;

  typedef struct packed {
    logic pop_go;
    logic dump_go;
    logic dump_last;
  } cdq_sts_t;

endpackage

// File: src/circular_deque.sv
// Double-ended queue over a 16-entry ring store. A command beat is taken when start is high
// and busy is low. Push commands and refused or unused commands leave busy low, so they can
// be issued back to back; pops hold busy high because the store has a registered read port.
// A read-out of N held entries gives N result beats, one per cycle, front to rear, with
// last set on the final one. Each result sits on out_item for one cycle under out_strobe:
// in the cycle after the command for pushes, refusals and unused codes; for pops and
// read-outs the data passes through the store's read register and then the output register.
// The receiver cannot stall, so it must take every beat in the cycle it is shown.
module circular_deque
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_item,
  output logic      out_strobe,
  output out_beat_t out_item
);

  cdq_ctl_t ctl;
  cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  cdq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .ctl        (ctl),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: src/cdq_ctrl.sv
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cdq_sts_t sts,
  output cdq_ctl_t ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POPOUT = 2'd1;
  localparam logic [1:0] S_DUMP   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    ctl.accept    = 1'b0;
    ctl.pop_emit  = 1'b0;
    ctl.dump_step = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          if (sts.pop_go) begin
            state_nxt = S_POPOUT;
          end else if (sts.dump_go) begin
            state_nxt = S_DUMP;
          end
        end
      end
      S_POPOUT: begin
        ctl.pop_emit = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DUMP: begin
        ctl.dump_step = 1'b1;
        if (sts.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: src/cdq_datapath.sv
`include "circular_deque_macros.svh"

module cdq_datapath
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_item,
  input  cdq_ctl_t  ctl,
  output cdq_sts_t  sts,
  output logic      out_strobe,
  output out_beat_t out_item
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] rd_r;

  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic                  strobe_r, strobe_nxt;
  out_beat_t             out_r, out_nxt;
  logic                  full;
  logic                  empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign sts.pop_go    = ((in_item.command == CMD_POP_FRONT) ||
                          (in_item.command == CMD_POP_REAR)) && !empty;
  assign sts.dump_go   = (in_item.command == CMD_READ_ALL) && !empty;
  assign sts.dump_last = ((CNT_W'(idx_r) + 1'b1) == count_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    rp_nxt     = rp_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    strobe_nxt = 1'b0;
    out_nxt    = '{status: ST_OK, data: '0, last: 1'b1, fill_count: '0};

    if (ctl.accept) begin
      case (in_item.command)
        CMD_PUSH_FRONT: begin
          strobe_nxt = 1'b1;
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            head_nxt  = ptr_dec(head_r);
            wr_en     = 1'b1;
            wr_addr   = ptr_dec(head_r);
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          strobe_nxt = 1'b1;
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            tail_nxt  = ptr_inc(tail_r);
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            strobe_nxt     = 1'b1;
            out_nxt.status = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = ptr_inc(head_r);
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (empty) begin
            strobe_nxt     = 1'b1;
            out_nxt.status = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ptr_dec(tail_r);
            tail_nxt  = ptr_dec(tail_r);
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_READ_ALL: begin
          if (empty) begin
            strobe_nxt     = 1'b1;
            out_nxt.status = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_r;
            rp_nxt  = ptr_inc(head_r);
            idx_nxt = '0;
          end
        end
        default: begin
          strobe_nxt = 1'b1;
        end
      endcase
    end else if (ctl.pop_emit) begin
      strobe_nxt   = 1'b1;
      out_nxt.data = VAL_W'(rd_r);
    end else if (ctl.dump_step) begin
      strobe_nxt   = 1'b1;
      out_nxt.data = VAL_W'(rd_r);
      out_nxt.last = sts.dump_last;
      if (!sts.dump_last) begin
        // advance to the next held entry
        rd_en   = 1'b1;
        rd_addr = rp_r;
        rp_nxt  = ptr_inc(rp_r);
        idx_nxt = idx_r + 1'b1;
      end
    end

    out_nxt.fill_count = FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'($unsigned(in_item.value));
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r  <= rp_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  `CDQ_ASSERT_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(DEPTH), "count beyond depth")
  `CDQ_ASSERT(a_ptr_meet, clk, rst_n, ((count_r == '0) || full) |-> (head_r == tail_r), "pointers apart at empty or full")
  `CDQ_ASSERT(a_pop_after_accept, clk, rst_n, ctl.pop_emit |-> $past(ctl.accept), "pop beat without accepted command")
  `CDQ_ASSERT(a_dump_continues, clk, rst_n, (ctl.dump_step && !sts.dump_last) |=> ctl.dump_step, "read-out stopped early")

endmodule
